FILE: rtl/core/ufsk_pkg.sv
// ----------------------------------------------------------------------------
// ufsk_pkg: shared types and constants for the framed fsk modulator
// Holds the cosine magnitude table, register indexes, reset values and codes.
// ----------------------------------------------------------------------------
package ufsk_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int FRAME_BITS      = 10;
  localparam int COS_TABLE_BITS  = 10;
  localparam int PHASE_BITS      = 32;
  localparam int QUARTER_BITS    = COS_TABLE_BITS - 2;
  localparam int QTR_N           = 1 << QUARTER_BITS;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LEVEL_W    = 9;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MARK_STEP       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPACE_STEP      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_BIT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_AMPLITUDE       = 2'd3;

  localparam logic [31:0] MARK_STEP_RST       = 32'd107374182;
  localparam logic [31:0] SPACE_STEP_RST      = 32'd196852668;
  localparam logic [7:0]  SAMPLES_PER_BIT_RST = 8'd40;
  localparam logic [14:0] AMPLITUDE_RST       = 15'd32000;

  // item kinds
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef logic [15:0] cos_mag_t;
  typedef cos_mag_t cos_tab_t [0:QTR_N];

  // q30 even polynomial of cos over a quarter wave, u is q16, result q15
  function automatic cos_mag_t quarter_cos(input longint u);
    longint coef [0:5];
    longint x2;
    longint acc;
    coef[0] = 64'sd1073741824;
    coef[1] = -64'sd1324675879;
    coef[2] = 64'sd272375560;
    coef[3] = -64'sd22401992;
    coef[4] = 64'sd987048;
    coef[5] = -64'sd27061;
    x2  = (u * u) >>> 16;
    acc = coef[5];
    for (int k = 4; k >= 0; k--) begin
      acc = coef[k] + (acc * x2) / 64'sd65536;
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 64'sd32768) begin
      acc = 64'sd32768;
    end
    return acc[15:0];
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    for (int m = 0; m <= QTR_N; m++) begin
      t[m] = quarter_cos(longint'(m) << (16 - QUARTER_BITS));
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

FILE: rtl/core/ufsk_queue.sv
// ----------------------------------------------------------------------------
// ufsk_queue: byte queue
// Circular buffer in a memory with registered read data and a fill count.
// ----------------------------------------------------------------------------
module ufsk_queue #(
  parameter int DEPTH = ufsk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ufsk_pkg::queue_ctrl_t        ctrl,
  input  logic [7:0]                   wr_data,
  output logic [7:0]                   rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic                         full,
  output logic                         empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [7:0]       mem [0:DEPTH-1];
  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = rd_data_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctrl.push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end else if (ctrl.pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (ctrl.pop && !empty) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

FILE: rtl/core/ufsk_tone.sv
// ----------------------------------------------------------------------------
// ufsk_tone: phase accumulator and cosine scaler
// Holds the phase, looks up the folded cosine and scales it by the amplitude.
// ----------------------------------------------------------------------------
module ufsk_tone (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               use_mark,
  input  logic [31:0]        mark_step,
  input  logic [31:0]        space_step,
  input  logic [14:0]        amplitude,
  output logic signed [15:0] sample
);

  localparam int PW  = ufsk_pkg::PHASE_BITS;
  localparam int CTB = ufsk_pkg::COS_TABLE_BITS;
  localparam int QB  = ufsk_pkg::QUARTER_BITS;
  localparam logic [QB:0] QTR_FULL = (QB + 1)'(ufsk_pkg::QTR_N);

  logic [PW-1:0]  phase_r, phase_nxt;
  logic [PW-1:0]  step;
  logic [CTB-1:0] idx;
  logic [1:0]     quad;
  logic [QB:0]    m;
  logic [15:0]    mag;
  logic [30:0]    prod;
  logic [15:0]    v;

  assign step      = PW'(use_mark ? mark_step : space_step);
  assign phase_nxt = advance ? phase_r + step : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // fold to a quarter wave, odd quadrants run the table backwards
  assign idx  = phase_r[PW-1 -: CTB];
  assign quad = idx[CTB-1 -: 2];
  assign m    = quad[0] ? (QTR_FULL - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
  assign mag  = ufsk_pkg::COS_TAB[m];
  assign prod = 31'(amplitude) * 31'(mag);
  assign v    = prod[30:15];

  always_comb begin
    if (quad == 2'd1 || quad == 2'd2) begin
      sample = $signed(~v + 16'd1);
    end else begin
      sample = $signed(v);
    end
  end

endmodule

FILE: rtl/core/uart_framed_fsk_modulator_top.sv
// ----------------------------------------------------------------------------
// uart_framed_fsk_modulator_top: queued byte to two-tone audio modulator
// Push transactions fill a byte queue, tick transactions emit one sample each.
// ----------------------------------------------------------------------------
// result: each result is registered in the cycle after its input is accepted
// throughput: one transaction per cycle without output stalls, bounded by the
//   single-pass sample path (table lookup, one 15x16 multiply, sign) between
//   state and output register
// reset: synchronous active-low rst_n clears queue pointers, phase, framing
//   state and the output valid; config registers return to their defaults
// ----------------------------------------------------------------------------
module uart_framed_fsk_modulator_top #(
  parameter int QUEUE_DEPTH = ufsk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [ufsk_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ufsk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] byte_value
  input  logic                                in_tuser,   // [0] mode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] sample, [16] byte_accepted, [25:17] queue_level, [31:26] zero
  output logic [31:0]                         out_tdata,
  output logic                                out_tuser   // [0] sample_valid
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BIT_W = $clog2(ufsk_pkg::FRAME_BITS);
  localparam int FB    = ufsk_pkg::FRAME_BITS;
  localparam int LW    = ufsk_pkg::LEVEL_W;
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(FB - 1);

  // config registers
  logic [31:0] mark_step_r;
  logic [31:0] space_step_r;
  logic [7:0]  spb_r;
  logic [14:0] amplitude_r;

  // framing state
  logic [FB-1:0]    fs_r, fs_nxt;
  logic [BIT_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [7:0]       samp_idx_r, samp_idx_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_shift_r, pend_shift_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_sample_r;
  logic             out_sv_r;
  logic             out_ba_r;
  logic [LW-1:0]    out_lvl_r;

  // queue and tone hookup
  ufsk_pkg::queue_ctrl_t q_ctrl;
  logic [7:0]        q_rd_data;
  logic [CNT_W-1:0]  q_count;
  logic              q_full;
  logic              q_empty;
  logic signed [15:0] tone_sample;

  logic              in_acc;
  logic              tick;
  logic              push_req;
  logic              push_ok;
  logic              frame_start;
  logic              do_pop;
  logic [FB-1:0]     fs_full;
  logic [FB-1:0]     fs_cur;
  logic [FB-1:0]     fs_tick;
  logic [7:0]        spb;
  logic [7:0]        si_inc;
  logic              bit_end;
  logic [CNT_W-1:0]  count_after;
  logic [CNT_W+LW-1:0] lvl_ext;

  // output register frees the input side as soon as its result is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_acc && (in_tuser == ufsk_pkg::MODE_TICK);
  assign push_req  = in_acc && (in_tuser == ufsk_pkg::MODE_PUSH);
  assign push_ok   = push_req && !q_full;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_step_r  <= ufsk_pkg::MARK_STEP_RST;
      space_step_r <= ufsk_pkg::SPACE_STEP_RST;
      spb_r        <= ufsk_pkg::SAMPLES_PER_BIT_RST;
      amplitude_r  <= ufsk_pkg::AMPLITUDE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        ufsk_pkg::CFG_MARK_STEP:       mark_step_r  <= cfg_wdata;
        ufsk_pkg::CFG_SPACE_STEP:      space_step_r <= cfg_wdata;
        ufsk_pkg::CFG_SAMPLES_PER_BIT: spb_r        <= cfg_wdata[7:0];
        ufsk_pkg::CFG_AMPLITUDE:       amplitude_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // frame start pops the next byte; its data lands in the read register in the
  // cycle after the pop, and only the start bit is needed in the popping tick
  assign frame_start = (bit_idx_r == '0) && (samp_idx_r == '0);
  assign do_pop      = tick && frame_start && !q_empty;

  // start bit, inverted byte lsb first, stop bit
  assign fs_full = {1'b0, ~q_rd_data, 1'b1};
  // merge the freshly read byte, accounting for a one-sample bit already done
  assign fs_cur  = pend_r ? (pend_shift_r ? (fs_full >> 1) : fs_full) : fs_r;
  // empty queue at frame start sends an all-zero frame
  assign fs_tick = frame_start ? {{(FB-1){1'b0}}, do_pop} : fs_cur;

  // zero samples per bit acts as one
  assign spb     = (spb_r == 8'd0) ? 8'd1 : spb_r;
  assign si_inc  = samp_idx_r + 8'd1;
  assign bit_end = (si_inc >= spb) || (si_inc == 8'd0);

  always_comb begin
    fs_nxt         = fs_cur;
    bit_idx_nxt    = bit_idx_r;
    samp_idx_nxt   = samp_idx_r;
    pend_nxt       = 1'b0;
    pend_shift_nxt = 1'b0;
    if (tick) begin
      pend_nxt       = do_pop;
      pend_shift_nxt = do_pop && bit_end;
      if (bit_end) begin
        samp_idx_nxt = 8'd0;
        fs_nxt       = fs_tick >> 1;
        bit_idx_nxt  = (bit_idx_r == BIT_LAST) ? '0 : bit_idx_r + 1'b1;
      end else begin
        samp_idx_nxt = si_inc;
        fs_nxt       = fs_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r         <= '0;
      bit_idx_r    <= '0;
      samp_idx_r   <= '0;
      pend_r       <= 1'b0;
      pend_shift_r <= 1'b0;
    end else begin
      fs_r         <= fs_nxt;
      bit_idx_r    <= bit_idx_nxt;
      samp_idx_r   <= samp_idx_nxt;
      pend_r       <= pend_nxt;
      pend_shift_r <= pend_shift_nxt;
    end
  end

  assign q_ctrl.push = push_ok;
  assign q_ctrl.pop  = do_pop;

  ufsk_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .wr_data (in_tdata),
    .rd_data (q_rd_data),
    .count   (q_count),
    .full    (q_full),
    .empty   (q_empty)
  );

  ufsk_tone u_tone (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (tick),
    .use_mark   (fs_tick[0]),
    .mark_step  (mark_step_r),
    .space_step (space_step_r),
    .amplitude  (amplitude_r),
    .sample     (tone_sample)
  );

  // queue level after this transaction
  always_comb begin
    if (push_ok) begin
      count_after = q_count + 1'b1;
    end else if (do_pop) begin
      count_after = q_count - 1'b1;
    end else begin
      count_after = q_count;
    end
  end
  assign lvl_ext = {{LW{1'b0}}, count_after};

  // result register
  assign out_valid_nxt = in_acc ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_sample_r <= tick ? tone_sample : 16'd0;
      out_sv_r     <= tick;
      out_ba_r     <= push_ok;
      out_lvl_r    <= lvl_ext[LW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_lvl_r, out_ba_r, out_sample_r};
  assign out_tuser  = out_sv_r;

  // the read byte is merged in the cycle right after the pop, never later
  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r)
    else $error("pop merge pending for more than one cycle");

  a_bit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r < BIT_W'(FB))
    else $error("bit index beyond frame");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (push_req && q_full) |=> (out_tvalid && !out_tdata[16] && !out_tuser))
    else $error("push into full queue was not flagged as dropped");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (out_tvalid && out_tuser && !out_tdata[16]))
    else $error("tick transaction did not produce a sample result");

endmodule

FILE: dv/tb_uart_framed_fsk_modulator_top.sv
// ----------------------------------------------------------------------------
// tb_uart_framed_fsk_modulator_top: self-checking bench for the fsk modulator
// Drives push and tick transactions with random bursts and output stalls.
// Typed rows check hand-written results, others a cycle-free behavioral model
// of queue, uart framing and cosine sample path over several register settings.
// ----------------------------------------------------------------------------
module tb_uart_framed_fsk_modulator_top;

  localparam int FIFO_DEPTH = ufsk_pkg::QUEUE_DEPTH_DEF;

  // one result transaction, split into its fields
  typedef struct packed {
    logic [15:0] smp;
    logic        smp_valid;
    logic        accepted;
    logic [8:0]  level;
  } result_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    logic        mode;
    logic [7:0]  data;
    logic        typed;
    result_t     want;
  } row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_wr_en = 1'b0;
  logic [ufsk_pkg::CFG_ADDR_W-1:0]    cfg_addr = '0;
  logic [ufsk_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [7:0]                         in_tdata = '0;    // [7:0] byte_value
  logic                               in_tuser = 1'b0;  // [0] mode
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  // [15:0] sample, [16] byte_accepted, [25:17] queue_level, [31:26] zero
  logic [31:0]                        out_tdata;
  logic                               out_tuser;        // [0] sample_valid

  // shadow of the modulator: register copies and datapath state
  logic [31:0] reg_mark  = ufsk_pkg::MARK_STEP_RST;
  logic [31:0] reg_space = ufsk_pkg::SPACE_STEP_RST;
  logic [7:0]  reg_spb   = ufsk_pkg::SAMPLES_PER_BIT_RST;
  logic [14:0] reg_amp   = ufsk_pkg::AMPLITUDE_RST;
  logic [7:0]  fifo_shadow [$];
  logic [31:0] phase_acc  = '0;
  logic [9:0]  frame_bits = '0;
  logic [3:0]  bit_pos    = '0;
  logic [7:0]  smp_pos    = '0;

  result_t     outputs_due [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  logic [9:0]  rx_cyc = '0;
  result_t     got_r;
  result_t     want_r;
  row_t        rows [0:20];

  uart_framed_fsk_modulator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // amplitude * cos(phase) from the top ten phase bits, quarter-wave folded,
  // magnitude by an even taylor series in q30, rounded to q15
  function automatic logic [15:0] tone_sample(input logic [31:0] ph, input logic [14:0] amp);
    logic [9:0] idx;
    logic [8:0] m;
    longint     u;
    longint     x2;
    longint     acc;
    longint     v;
    idx = ph[31:22];
    m   = idx[8] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
    u   = longint'(m) << 8;
    x2  = (u * u) >>> 16;
    // horner steps, division truncates toward zero
    acc = -27061;
    acc = 987048 + (acc * x2) / 65536;
    acc = -22401992 + (acc * x2) / 65536;
    acc = 272375560 + (acc * x2) / 65536;
    acc = -1324675879 + (acc * x2) / 65536;
    acc = 1073741824 + (acc * x2) / 65536;
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32768) begin
      acc = 32768;
    end
    v = (longint'(amp) * acc) >>> 15;
    // second and third quadrant are negative
    if (idx[9] != idx[8]) begin
      v = -v;
    end
    return v[15:0];
  endfunction

  // advance the shadow by one accepted transaction and return its result
  function automatic result_t modulate_item(input logic mode, input logic [7:0] data);
    result_t    r;
    logic [7:0] head;
    logic [7:0] spb;
    r = '0;
    if (mode == ufsk_pkg::MODE_PUSH) begin
      // full queue drops the byte and leaves everything else alone
      if (fifo_shadow.size() < FIFO_DEPTH) begin
        fifo_shadow.push_back(data);
        r.accepted = 1'b1;
      end
      r.level = 9'(fifo_shadow.size());
      return r;
    end
    // frame start: start bit 1, inverted byte lsb first, stop bit 0;
    // an empty queue sends an all-zero frame
    if (bit_pos == 4'd0 && smp_pos == 8'd0) begin
      frame_bits = '0;
      if (fifo_shadow.size() != 0) begin
        head = fifo_shadow.pop_front();
        frame_bits = {1'b0, ~head, 1'b1};
      end
    end
    r.smp       = tone_sample(phase_acc, reg_amp);
    r.smp_valid = 1'b1;
    spb = (reg_spb == 8'd0) ? 8'd1 : reg_spb;
    phase_acc = phase_acc + (frame_bits[0] ? reg_mark : reg_space);
    smp_pos = smp_pos + 8'd1;
    // a lowered bit length ends the current bit at once
    if (smp_pos >= spb || smp_pos == 8'd0) begin
      smp_pos    = '0;
      frame_bits = frame_bits >> 1;
      bit_pos    = bit_pos + 4'd1;
      if (bit_pos >= 4'(ufsk_pkg::FRAME_BITS)) begin
        bit_pos = '0;
      end
    end
    r.level = 9'(fifo_shadow.size());
    return r;
  endfunction

  function automatic row_t row(input logic mode, input logic [7:0] data, input logic typed,
                               input logic [15:0] smp, input logic smp_valid,
                               input logic accepted, input logic [8:0] level);
    row_t t;
    t.mode = mode;
    t.data = data;
    t.typed = typed;
    t.want.smp = smp;
    t.want.smp_valid = smp_valid;
    t.want.accepted = accepted;
    t.want.level = level;
    return t;
  endfunction

  // one register write; the enable stays up for a following write
  task automatic cfg_write(input logic [ufsk_pkg::CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      ufsk_pkg::CFG_MARK_STEP:       reg_mark  = value;
      ufsk_pkg::CFG_SPACE_STEP:      reg_space = value;
      ufsk_pkg::CFG_SAMPLES_PER_BIT: reg_spb   = value[7:0];
      ufsk_pkg::CFG_AMPLITUDE:       reg_amp   = value[14:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] mark, input logic [31:0] space,
                              input logic [7:0] spb, input logic [14:0] amp);
    cfg_write(ufsk_pkg::CFG_MARK_STEP, mark);
    cfg_write(ufsk_pkg::CFG_SPACE_STEP, space);
    cfg_write(ufsk_pkg::CFG_SAMPLES_PER_BIT, {24'd0, spb});
    cfg_write(ufsk_pkg::CFG_AMPLITUDE, {17'd0, amp});
    cfg_wr_en <= 1'b0;
  endtask

  // hold the sender off until every result is back, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outputs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // one input transaction in bursts: gaps open only between bursts
  task automatic send_item(input logic mode, input logic [7:0] data, input logic typed,
                           input result_t want);
    result_t pred;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long run without gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do begin
      @(posedge clk);
    end while (!in_tready);
    pred = modulate_item(mode, data);
    outputs_due.push_back(typed ? want : pred);
  endtask

  task automatic run_random(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      send_item(($urandom_range(0, 99) < push_pct) ? ufsk_pkg::MODE_PUSH : ufsk_pkg::MODE_TICK,
                8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  // receiver stall pattern, changing style with bits 9:8 of a free-running cycle counter
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 10'd1;
    case (rx_cyc[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= rx_cyc[3] | rx_cyc[1];
      default: out_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // result checker: each accepted result against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r.smp       = out_tdata[15:0];
      got_r.accepted  = out_tdata[16];
      got_r.level     = out_tdata[25:17];
      got_r.smp_valid = out_tuser;
      if (outputs_due.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: sample %0d valid %0b accepted %0b level %0d",
                   $signed(got_r.smp), got_r.smp_valid, got_r.accepted, got_r.level);
        end
        mismatch_count++;
      end else begin
        want_r = outputs_due.pop_front();
        if (got_r.smp !== want_r.smp || got_r.smp_valid !== want_r.smp_valid ||
            got_r.accepted !== want_r.accepted || got_r.level !== want_r.level) begin
          if (mismatch_count < 10) begin
            $display("mismatch: sample %0d/%0d valid %0b/%0b accepted %0b/%0b level %0d/%0d",
                     $signed(want_r.smp), $signed(got_r.smp), want_r.smp_valid,
                     got_r.smp_valid, want_r.accepted, got_r.accepted, want_r.level,
                     got_r.level);
          end
          mismatch_count++;
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    // defaults: first tick after reset sits at phase zero on an empty queue
    rows[0]  = row(ufsk_pkg::MODE_TICK, 8'h00, 1'b1, 16'd32000, 1'b1, 1'b0, 9'd0);
    rows[1]  = row(ufsk_pkg::MODE_PUSH, 8'h00, 1'b1, 16'd0, 1'b0, 1'b1, 9'd1);
    rows[2]  = row(ufsk_pkg::MODE_PUSH, 8'hff, 1'b1, 16'd0, 1'b0, 1'b1, 9'd2);
    rows[3]  = row(ufsk_pkg::MODE_PUSH, 8'ha5, 1'b1, 16'd0, 1'b0, 1'b1, 9'd3);
    rows[4]  = row(ufsk_pkg::MODE_PUSH, 8'h5a, 1'b1, 16'd0, 1'b0, 1'b1, 9'd4);
    rows[5]  = row(ufsk_pkg::MODE_TICK, 8'hff, 1'b0, 16'd0, 1'b0, 1'b0, 9'd0);
    rows[6]  = row(ufsk_pkg::MODE_TICK, 8'h3c, 1'b0, 16'd0, 1'b0, 1'b0, 9'd0);
    rows[7]  = row(ufsk_pkg::MODE_TICK, 8'hc3, 1'b0, 16'd0, 1'b0, 1'b0, 9'd0);
    rows[8]  = row(ufsk_pkg::MODE_PUSH, 8'h80, 1'b1, 16'd0, 1'b0, 1'b1, 9'd5);
    rows[9]  = row(ufsk_pkg::MODE_PUSH, 8'h01, 1'b1, 16'd0, 1'b0, 1'b1, 9'd6);
    // zero amplitude, one sample per bit: the bit in flight ends on the next
    // tick, the rest of the empty frame runs out, then the first byte pops
    for (int i = 10; i < 20; i++) begin
      rows[i] = row(ufsk_pkg::MODE_TICK, 8'(i * 37), 1'b1, 16'd0, 1'b1, 1'b0, 9'd6);
    end
    rows[20] = row(ufsk_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0, 1'b1, 1'b0, 9'd5);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 21; i++) begin
      if (i == 10) begin
        settle();
        program_regs(ufsk_pkg::MARK_STEP_RST, ufsk_pkg::SPACE_STEP_RST, 8'd1, 15'd0);
      end
      send_item(rows[i].mode, rows[i].data, rows[i].typed, rows[i].want);
    end

    // random phases over a spread of register settings
    settle();
    program_regs($urandom, $urandom, 8'd3, 15'h7fff);
    run_random(200, 30);
    // zero mark step, full-scale space step, zero bit length taken as one
    settle();
    program_regs(32'h0000_0000, 32'hffff_ffff, 8'd0, 15'h7fff);
    run_random(150, 20);
    // longest bits, left mid-bit by the next phase's short bit length
    settle();
    program_regs(32'hffff_ffff, 32'h0000_0000, 8'd255, 15'd1);
    run_random(60, 10);
    settle();
    program_regs(ufsk_pkg::MARK_STEP_RST, ufsk_pkg::SPACE_STEP_RST, 8'd2,
                 ufsk_pkg::AMPLITUDE_RST);
    run_random(200, 25);
    // flood the queue until bytes are dropped
    settle();
    program_regs($urandom, $urandom, 8'd1, 15'($urandom));
    run_random(320, 95);
    // drain with few pushes, some still hitting a full queue
    settle();
    program_regs($urandom, $urandom, 8'd1, 15'($urandom));
    run_random(300, 5);
    settle();
    program_regs($urandom, $urandom, 8'($urandom_range(1, 16)), 15'($urandom));
    run_random(250, 30);

    in_tvalid <= 1'b0;
    while (outputs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
